### rtl/rsa_public_key_engine_core_defines.svh
// ---------------------------------------------------------------------------
// RSA public-key engine assertion macros
// Shared concurrent-check shorthands; clocked on clk, off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef RSA_PUBLIC_KEY_ENGINE_CORE_DEFINES_SVH
`define RSA_PUBLIC_KEY_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define RSAPKE_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSAPKE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rsapke_pkg.sv
// ---------------------------------------------------------------------------
// RSA public-key engine package
// Register map, command codes and size constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsapke_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 10;

	localparam int SEGMENT_WORDS_DEF = 512;
	localparam int MAX_LIMBS_DEF     = 64;

	// register map, word index
	localparam logic [IDX_W-1:0] W_CONTROL   = 10'd0;
	localparam logic [IDX_W-1:0] W_COMMAND   = 10'd2;
	localparam logic [IDX_W-1:0] W_OPERATION = 10'd3;
	localparam logic [IDX_W-1:0] W_STATUS    = 10'd4;
	localparam logic [IDX_W-1:0] W_SEGSETUP  = 10'd5;
	localparam logic [IDX_W-1:0] W_SWRESET   = 10'd9;
	localparam logic [IDX_W-1:0] W_SEGBASE   = 10'h200;

	// commands
	localparam logic [WORD_W-1:0] CMD_LAUNCH = 32'd1;
	localparam logic [WORD_W-1:0] CMD_ARM    = 32'd9;

	// operation word fields
	localparam logic [WORD_W-1:0] LAUNCH_OP    = 32'h0202_0001;
	localparam logic [7:0]        ARM_OP_CLASS = 8'h01;
	localparam logic [7:0]        ARM_OP_MID   = 8'h00;
	localparam logic [7:0]        ARM_OP_KIND  = 8'h03;

	localparam logic [16:0] RSA_EXP    = 17'h1_0001;
	localparam logic [7:0]  BASE_LIMBS = 8'd64;

endpackage

### rtl/rsapke_if.sv
// ---------------------------------------------------------------------------
// RSA public-key engine channels
// Valid/ready request and response channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rsapke_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [rsapke_pkg::IDX_W-1:0]  word_index;
	logic [rsapke_pkg::WORD_W-1:0] write_data;

	modport source (output valid, kind, word_index, write_data, input ready);
	modport sink   (input valid, kind, word_index, write_data, output ready);
endinterface

interface rsapke_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rsapke_pkg::WORD_W-1:0] read_data;
	logic                         op_rejected;

	modport source (output valid, read_data, op_rejected, input ready);
	modport sink   (input valid, read_data, op_rejected, output ready);
endinterface

### rtl/rsapke_ram.sv
// ---------------------------------------------------------------------------
// RSA public-key engine RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsapke_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/rsa_public_key_engine_core.sv
// ---------------------------------------------------------------------------
// RSA public-key engine core
// Register-mapped engine computing base^65537 mod n over a segment RAM.
// ---------------------------------------------------------------------------
// Register and segment-write requests are answered directly from idle;
// segment reads pass through a read state for the registered RAM read.
// A launch request (command 1 while armed) holds the request channel off
// until the exponentiation ends: every step is a limb-serial pass of one
// 32-bit add/subtract unit over the n limbs, and a modular multiply costs
// 32n bit steps of two passes, plus two more when the multiplier bit is
// set. The run is 17 squarings, two base multiplies, the base reduction
// and the load/store passes. After reset and after a software reset the
// segment RAM is cleared one word a cycle, during which no request is
// taken.
`timescale 1ns / 1ps
`include "rsa_public_key_engine_core_defines.svh"

module rsa_public_key_engine_core #(
	parameter int SEGMENT_WORDS = rsapke_pkg::SEGMENT_WORDS_DEF,
	parameter int MAX_LIMBS     = rsapke_pkg::MAX_LIMBS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rsapke_req_if.sink   req,
	rsapke_rsp_if.source rsp
);

	import rsapke_pkg::*;

	localparam int LW = $clog2(MAX_LIMBS);   // limb index
	localparam int CW = LW + 1;              // limb count, holds n
	localparam int SW = $clog2(SEGMENT_WORDS);
	localparam int KW = LW + 5;              // bit index within operand

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SEGRD, S_LOADM, S_LOADR, S_ZERO, S_FETCH, S_LATCH,
		S_SUM, S_FIN, S_COPY, S_ONE, S_STORE
	} state_t;

	// what the shared multiply loop is doing: base reduction, square, times base
	typedef enum logic [1:0] {MUL_RED, MUL_SQR, MUL_BASE} mul_mode_t;

	state_t            state_q;
	mul_mode_t         mode_q;
	logic [WORD_W-1:0] ctrl_q, op_q, stat_q, setup_q;
	logic              armed_q;
	logic              rsp_valid_q, rej_q;
	logic [WORD_W-1:0] rd_q;
	logic [CW-1:0]     n_q, cnt_q;
	logic [KW-1:0]     kbit_q;
	logic [4:0]        ebit_q;
	logic [WORD_W-1:0] ybits_q;
	logic              carry_q, borrow_q, sel_q, add_q, nz_q, one_q;
	logic [SW-1:0]     clr_q;

	// RAM ports
	logic              seg_we, m_we, b_we, r_we, a_we, t_we;
	logic [SW-1:0]     seg_wa, seg_ra;
	logic [WORD_W-1:0] seg_wd, m_wd, b_wd, r_wd, a_wd;
	logic [LW-1:0]     r_ra;
	logic [WORD_W-1:0] seg_rdata, m_rdata, b_rdata, r_rdata, a_rdata, t_rdata;

	// pass bookkeeping
	logic [CW-1:0] cnt_m1;
	logic [LW-1:0] pidx, lidx;
	logic          proc, pass_end, is_pass;
	logic [SW:0]   seg_nc, seg_np;

	// shared add/subtract unit
	logic [WORD_W-1:0] xsrc, s2, dmin, fin_val;
	logic [WORD_W:0]   sum33, diff33;

	// request decode
	logic              req_fire, in_win, arm_ok, fire_ok, size_bad;
	logic [IDX_W-1:0]  seg_off;
	logic [WORD_W-1:0] reg_rd;
	logic [7:0]        n_full;
	logic              nz_nx, one_nx;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.read_data = rd_q;
	assign rsp.op_rejected = rej_q;

	// window bound compared one bit wider, so that SEGMENT_WORDS may equal 2^IDX_W
	assign seg_off = req.word_index - W_SEGBASE;
	assign in_win  = (req.word_index >= W_SEGBASE)
		&& ({1'b0, seg_off} < (IDX_W+1)'(SEGMENT_WORDS));

	assign arm_ok = (req.write_data == CMD_ARM) && (op_q[31:24] == ARM_OP_CLASS)
		&& (op_q[15:8] == ARM_OP_MID) && (op_q[7:0] == ARM_OP_KIND);
	assign fire_ok = (req.write_data == CMD_LAUNCH) && setup_q[1]
		&& (op_q == LAUNCH_OP) && armed_q;

	// limb count 64 >> segment setup bits 7:6; only shifts 0..2 are legal (bits 31:6 <= 2)
	assign n_full   = BASE_LIMBS >> setup_q[7:6];
	assign size_bad = (setup_q[31:6] > 26'd2)
		|| ({24'b0, n_full} > 32'(MAX_LIMBS))
		|| ({23'b0, n_full, 1'b0} > 32'(SEGMENT_WORDS));

	always_comb begin
		unique case (req.word_index)
			W_CONTROL:   reg_rd = ctrl_q;
			W_OPERATION: reg_rd = op_q;
			W_STATUS:    reg_rd = stat_q;
			W_SEGSETUP:  reg_rd = setup_q;
			default:     reg_rd = '0;
		endcase
	end

	// a pass issues the read for limb cnt and retires limb cnt-1
	assign cnt_m1   = cnt_q - 1'b1;
	assign pidx     = cnt_m1[LW-1:0];
	assign lidx     = cnt_q[LW-1:0];
	assign proc     = (cnt_q != '0);
	assign pass_end = (cnt_q == n_q);
	assign seg_nc   = (SW+1)'(n_q) + (SW+1)'(cnt_q);
	assign seg_np   = (SW+1)'(n_q) + (SW+1)'(cnt_m1);
	assign is_pass  = (state_q == S_LOADM) || (state_q == S_LOADR) || (state_q == S_ZERO)
		|| (state_q == S_SUM) || (state_q == S_FIN) || (state_q == S_COPY)
		|| (state_q == S_ONE) || (state_q == S_STORE);

	assign nz_nx  = nz_q | (seg_rdata != '0);
	assign one_nx = one_q & (seg_rdata == ((pidx == '0) ? 32'd1 : 32'd0));

	// addend: A itself for the doubling step, else the multiplicand
	always_comb begin
		unique case (mode_q)
			MUL_RED: xsrc = (pidx == '0) ? 32'd1 : 32'd0;
			MUL_SQR: xsrc = r_rdata;
			default: xsrc = b_rdata;
		endcase
	end

	assign s2      = add_q ? xsrc : a_rdata;
	assign sum33   = {1'b0, a_rdata} + {1'b0, s2} + (WORD_W+1)'(carry_q);
	assign dmin    = (state_q == S_FIN) ? t_rdata : sum33[WORD_W-1:0];
	assign diff33  = {1'b0, dmin} - {1'b0, m_rdata} - (WORD_W+1)'(borrow_q);
	assign fin_val = sel_q ? diff33[WORD_W-1:0] : t_rdata;

	// RAM control
	always_comb begin
		seg_we = 1'b0;
		seg_wa = seg_off[SW-1:0];
		seg_wd = req.write_data;
		seg_ra = seg_off[SW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				seg_we = 1'b1;
				seg_wa = clr_q;
				seg_wd = '0;
			end
			S_IDLE: begin
				seg_we = req_fire && in_win && req.kind;
			end
			S_LOADM: begin
				seg_ra = SW'(cnt_q);
			end
			S_LOADR: begin
				seg_ra = seg_nc[SW-1:0];
			end
			S_STORE: begin
				seg_we = proc;
				seg_wa = seg_np[SW-1:0];
				seg_wd = one_q ? '0 : r_rdata;
			end
			default: ;
		endcase
	end

	assign m_we = proc && (state_q == S_LOADM);
	assign m_wd = seg_rdata;
	assign t_we = proc && (state_q == S_SUM);
	assign a_we = proc && ((state_q == S_ZERO) || (state_q == S_FIN));
	assign a_wd = (state_q == S_ZERO) ? '0 : fin_val;
	assign b_we = proc && (state_q == S_COPY) && (mode_q == MUL_RED);
	assign b_wd = a_rdata;
	assign r_we = proc && ((state_q == S_LOADR) || (state_q == S_ONE)
		|| ((state_q == S_COPY) && (mode_q != MUL_RED)));
	assign r_wd = (state_q == S_LOADR) ? seg_rdata
		: (state_q == S_ONE) ? ((pidx == '0) ? 32'd1 : 32'd0) : a_rdata;
	assign r_ra = (state_q == S_FETCH) ? kbit_q[KW-1:5] : lidx;

	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(SEGMENT_WORDS)) u_seg_ram (
		.clk(clk), .we(seg_we), .waddr(seg_wa), .wdata(seg_wd),
		.raddr(seg_ra), .rdata(seg_rdata)
	);

	// modulus
	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LIMBS)) u_m_ram (
		.clk(clk), .we(m_we), .waddr(pidx), .wdata(m_wd),
		.raddr(lidx), .rdata(m_rdata)
	);

	// reduced base
	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LIMBS)) u_b_ram (
		.clk(clk), .we(b_we), .waddr(pidx), .wdata(b_wd),
		.raddr(lidx), .rdata(b_rdata)
	);

	// running result, also raw base during the reduction
	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LIMBS)) u_r_ram (
		.clk(clk), .we(r_we), .waddr(pidx), .wdata(r_wd),
		.raddr(r_ra), .rdata(r_rdata)
	);

	// product accumulator
	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LIMBS)) u_a_ram (
		.clk(clk), .we(a_we), .waddr(pidx), .wdata(a_wd),
		.raddr(lidx), .rdata(a_rdata)
	);

	// unreduced sum
	rsapke_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LIMBS)) u_t_ram (
		.clk(clk), .we(t_we), .waddr(pidx), .wdata(sum33[WORD_W-1:0]),
		.raddr(lidx), .rdata(t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mode_q      <= MUL_RED;
			ctrl_q      <= '0;
			op_q        <= '0;
			stat_q      <= '0;
			setup_q     <= '0;
			armed_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rej_q       <= 1'b0;
			rd_q        <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			kbit_q      <= '0;
			ebit_q      <= '0;
			carry_q     <= 1'b0;
			borrow_q    <= 1'b0;
			sel_q       <= 1'b0;
			add_q       <= 1'b0;
			nz_q        <= 1'b0;
			one_q       <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (is_pass) begin
				cnt_q <= pass_end ? '0 : cnt_q + 1'b1;
			end

			// carry and borrow chains restart with every pass
			if (cnt_q == '0) begin
				carry_q  <= 1'b0;
				borrow_q <= 1'b0;
			end else if (state_q == S_SUM) begin
				carry_q  <= sum33[WORD_W];
				borrow_q <= diff33[WORD_W];
			end else if (state_q == S_FIN) begin
				borrow_q <= diff33[WORD_W];
			end

			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == SW'(SEGMENT_WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end

				S_IDLE: begin
					if (req_fire) begin
						rsp_valid_q <= 1'b1;
						rd_q        <= '0;
						rej_q       <= 1'b0;
						if (in_win) begin
							if (!req.kind) begin
								rsp_valid_q <= 1'b0;
								state_q     <= S_SEGRD;
							end
						end else if (!req.kind) begin
							rd_q <= reg_rd;
						end else begin
							unique case (req.word_index)
								W_CONTROL:   ctrl_q  <= req.write_data;
								W_OPERATION: op_q    <= req.write_data;
								W_STATUS:    stat_q  <= req.write_data;
								W_SEGSETUP:  setup_q <= req.write_data;
								W_SWRESET: begin
									ctrl_q  <= '0;
									op_q    <= '0;
									stat_q  <= '0;
									setup_q <= '0;
									armed_q <= 1'b0;
									clr_q   <= '0;
									state_q <= S_CLEAR;
								end
								W_COMMAND: begin
									if (arm_ok) begin
										armed_q <= 1'b1;
									end else if (fire_ok) begin
										armed_q <= 1'b0;
										if (size_bad) begin
											rej_q <= 1'b1;
										end else begin
											rsp_valid_q <= 1'b0;
											n_q         <= n_full[CW-1:0];
											nz_q        <= 1'b0;
											one_q       <= 1'b1;
											cnt_q       <= '0;
											state_q     <= S_LOADM;
										end
									end
								end
								default: ;
							endcase
						end
					end
				end

				S_SEGRD: begin
					rsp_valid_q <= 1'b1;
					rd_q        <= seg_rdata;
					rej_q       <= 1'b0;
					state_q     <= S_IDLE;
				end

				// modulus in, zero and one checks
				S_LOADM: begin
					if (proc) begin
						nz_q  <= nz_nx;
						one_q <= one_nx;
					end
					if (pass_end) begin
						if (!nz_nx) begin
							rsp_valid_q <= 1'b1;
							rd_q        <= '0;
							rej_q       <= 1'b1;
							state_q     <= S_IDLE;
						end else if (one_nx) begin
							state_q <= S_STORE;
						end else begin
							state_q <= S_LOADR;
						end
					end
				end

				S_LOADR: begin
					if (pass_end) begin
						mode_q  <= MUL_RED;
						state_q <= S_ZERO;
					end
				end

				S_ZERO: begin
					if (pass_end) begin
						kbit_q  <= {cnt_m1[LW-1:0], 5'h1f};
						state_q <= S_FETCH;
					end
				end

				S_FETCH: state_q <= S_LATCH;

				S_LATCH: begin
					ybits_q <= r_rdata;
					add_q   <= 1'b0;
					state_q <= S_SUM;
				end

				S_SUM: begin
					if (pass_end) begin
						sel_q   <= sum33[WORD_W] | ~diff33[WORD_W];
						state_q <= S_FIN;
					end
				end

				S_FIN: begin
					if (pass_end) begin
						if (!add_q && ybits_q[kbit_q[4:0]]) begin
							add_q   <= 1'b1;
							state_q <= S_SUM;
						end else if (kbit_q == '0) begin
							state_q <= S_COPY;
						end else begin
							kbit_q  <= kbit_q - 1'b1;
							add_q   <= 1'b0;
							state_q <= (kbit_q[4:0] == 5'd0) ? S_FETCH : S_SUM;
						end
					end
				end

				S_COPY: begin
					if (pass_end) begin
						unique case (mode_q)
							MUL_RED: state_q <= S_ONE;
							MUL_SQR: begin
								if (RSA_EXP[ebit_q]) begin
									mode_q <= MUL_BASE;
								end else begin
									ebit_q <= ebit_q - 1'b1;
								end
								state_q <= S_ZERO;
							end
							default: begin
								if (ebit_q == '0) begin
									state_q <= S_STORE;
								end else begin
									ebit_q  <= ebit_q - 1'b1;
									mode_q  <= MUL_SQR;
									state_q <= S_ZERO;
								end
							end
						endcase
					end
				end

				// result starts at one
				S_ONE: begin
					if (pass_end) begin
						ebit_q  <= 5'd16;
						mode_q  <= MUL_SQR;
						state_q <= S_ZERO;
					end
				end

				S_STORE: begin
					if (pass_end) begin
						rsp_valid_q <= 1'b1;
						rd_q        <= '0;
						rej_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RSAPKE_ASSERT_IMPL(a_rsp_slot_free, req.ready, !rsp_valid_q || rsp.ready, "request taken with response slot busy")
	`RSAPKE_ASSERT_IMPL(a_clear_blocks, state_q == S_CLEAR, !req.ready, "request taken during RAM clear")
	`RSAPKE_ASSERT_IMPL(a_limbs_set, state_q == S_LOADM, n_q != '0, "launch with zero limb count")
	`RSAPKE_ASSERT_NEXT(a_fetch_latch, state_q == S_FETCH, state_q == S_LATCH, "multiplier word fetch lost")
	`RSAPKE_ASSERT_NEXT(a_sum_fin, state_q == S_SUM && cnt_q == n_q, state_q == S_FIN, "sum pass not followed by reduce pass")

endmodule
